[src/mbs_pkg.sv]
// Shared types and constants for the metronome beat sequencer.
`timescale 1ns / 1ps
`default_nettype none

package mbs_pkg;

  localparam int SampleRateDef = 48000;
  localparam int MaxBeatsDef   = 16;
  localparam int InQDepth      = 2;
  localparam int DivNumW       = 42;
  localparam int DivDenW       = 32;

  localparam logic [4:0]  BeatNone   = 5'd31;
  localparam logic [10:0] ProgDone   = 11'd1024;
  localparam logic [6:0]  LfsrMod    = 7'd101;
  localparam logic [6:0]  PctFull    = 7'd100;
  localparam logic [15:0] LfsrSeed   = 16'hACE1;
  localparam logic [15:0] LfsrTaps   = 16'hB400;

  localparam logic [2:0] CfgStartBpm = 3'd0;
  localparam logic [2:0] CfgEndBpm   = 3'd1;
  localparam logic [2:0] CfgPattern  = 3'd2;
  localparam logic [2:0] CfgBpb      = 3'd3;
  localparam logic [2:0] CfgMode     = 3'd4;
  localparam logic [2:0] CfgPeriod   = 3'd5;
  localparam logic [2:0] CfgStep     = 3'd6;
  localparam logic [2:0] CfgRamp     = 3'd7;

  localparam logic [2:0] ModeNone    = 3'd0;
  localparam logic [2:0] ModeRampBar = 3'd1;
  localparam logic [2:0] ModeRampTck = 3'd2;
  localparam logic [2:0] ModeRandBar = 3'd3;
  localparam logic [2:0] ModeCntBar  = 3'd4;
  localparam logic [2:0] ModeRandBt  = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_PLAY  = 3'd1,
    OP_STOP  = 3'd2,
    OP_TRAIN = 3'd3,
    OP_TEMPO = 3'd4,
    OP_NOP   = 3'd5
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [12:0] frames;
    logic [9:0]  tempo;
  } item_t;

  typedef struct packed {
    logic [9:0]  start_bpm;
    logic [9:0]  end_bpm;
    logic [31:0] beat_pattern;
    logic [4:0]  beats_per_bar;
    logic [2:0]  training_mode;
    logic [6:0]  period_bars;
    logic [9:0]  step_value;
    logic [31:0] ramp_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  click_sound;
    logic        beat_fired;
    logic [3:0]  beat_index;
    logic [9:0]  current_bpm;
    logic [2:0]  active_mode;
    logic [10:0] progress;
  } res_t;

endpackage

`default_nettype wire

[src/metronome_beat_sequencer.sv]
// Top level: configuration registers, input queue and sequencer back end.
`timescale 1ns / 1ps
`default_nettype none

// Metronome beat sequencer. Beats enter through push/full into a two-entry
// queue and results leave through empty/pop, one result per input beat.
// A control op or a tick while stopped goes from idle straight to the emit state.
// A tick while playing runs the frame-counter check through the shared
// 42-step serial divider. A click adds a state to pick the sound, and, in
// the random and ramp modes, a random draw or a divider pass for ramp
// progress, and a divider pass for the click interval when the tempo
// changes. Start training of the random modes adds a state.
module metronome_beat_sequencer
  import mbs_pkg::*;
#(
  parameter int SampleRate = SampleRateDef,
  parameter int MaxBeats   = MaxBeatsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [12:0] buffer_frames_i,
  input  wire logic [9:0]  new_tempo_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       click_sound_o,
  output logic             beat_fired_o,
  output logic [3:0]       beat_index_o,
  output logic [9:0]       current_bpm_o,
  output logic [2:0]       active_mode_o,
  output logic [10:0]      progress_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_pop;
  res_t  res;
  logic  res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_bpm     <= 10'd120;
      cfg_q.end_bpm       <= 10'd200;
      cfg_q.beat_pattern  <= 32'h5555_5555;
      cfg_q.beats_per_bar <= 5'd4;
      cfg_q.training_mode <= ModeNone;
      cfg_q.period_bars   <= 7'd4;
      cfg_q.step_value    <= 10'd5;
      cfg_q.ramp_ticks    <= 32'd60000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartBpm: cfg_q.start_bpm     <= cfg_data_i[9:0];
        CfgEndBpm:   cfg_q.end_bpm       <= cfg_data_i[9:0];
        CfgPattern:  cfg_q.beat_pattern  <= cfg_data_i;
        CfgBpb:      cfg_q.beats_per_bar <= cfg_data_i[4:0];
        CfgMode:     cfg_q.training_mode <= cfg_data_i[2:0];
        CfgPeriod:   cfg_q.period_bars   <= cfg_data_i[6:0];
        CfgStep:     cfg_q.step_value    <= cfg_data_i[9:0];
        CfgRamp:     cfg_q.ramp_ticks    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mbs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .buffer_frames_i(buffer_frames_i),
    .new_tempo_i    (new_tempo_i),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop)
  );

  mbs_back #(
    .SampleRate(SampleRate),
    .MaxBeats  (MaxBeats)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_pop_o  (item_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty         = !res_valid;
  assign click_sound_o = res.click_sound;
  assign beat_fired_o  = res.beat_fired;
  assign beat_index_o  = res.beat_index;
  assign current_bpm_o = res.current_bpm;
  assign active_mode_o = res.active_mode;
  assign progress_o    = res.progress;

endmodule

`default_nettype wire

[src/mbs_front.sv]
// Input queue: takes beats, classifies the opcode and holds them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module mbs_front
  import mbs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [12:0] buffer_frames_i,
  input  wire logic [9:0]  new_tempo_i,
  output item_t            item_o,
  output logic             item_valid_o,
  input  wire logic        item_pop_i
);

  localparam int PtrW = (InQDepth > 1) ? $clog2(InQDepth) : 1;
  localparam int CntW = $clog2(InQDepth + 1);

  item_t           mem_q [InQDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;
  item_t           in_item;

  always_comb begin
    in_item.frames = buffer_frames_i;
    in_item.tempo  = new_tempo_i;
    case (opcode_i)
      OP_TICK:  in_item.op = OP_TICK;
      OP_PLAY:  in_item.op = OP_PLAY;
      OP_STOP:  in_item.op = OP_STOP;
      OP_TRAIN: in_item.op = OP_TRAIN;
      OP_TEMPO: in_item.op = OP_TEMPO;
      default:  in_item.op = OP_NOP;
    endcase
  end

  assign full         = (cnt_q == CntW'(InQDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(InQDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(InQDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/mbs_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mbs_div #(
  parameter int NumW = 42,
  parameter int DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o,
  output logic [DenW-1:0]      rem_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial  = {rem_q, quo_q[NumW-1]};
  assign ge     = (trial >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/mbs_back.sv]
// Sequencer back end: tick handling, beat, training modes, tempo and result register.
`timescale 1ns / 1ps
`default_nettype none

module mbs_back
  import mbs_pkg::*;
#(
  parameter int SampleRate = SampleRateDef,
  parameter int MaxBeats   = MaxBeatsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  input  wire logic  item_valid_i,
  output logic       item_pop_o,
  output res_t       res_o,
  output logic       res_valid_o,
  input  wire logic  res_pop_i
);

  localparam logic [DivNumW-1:0] ClickNum = DivNumW'(60 * SampleRate);
  localparam logic [5:0]         MaxBt    = 6'(MaxBeats);
  // floor(v / 101) = (v * RandRecip) >> 22 for any 16-bit v
  localparam logic [15:0]        RandRecip = 16'd41528;
  // floor(x / 25) = (x * PctRecip) >> 20 for x below 25600
  localparam logic [15:0]        PctRecip  = 16'd41944;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FCDIV = 6'b000010,
    S_MDIV  = 6'b000100,
    S_SOUND = 6'b001000,
    S_IDIV  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    K_COMP   = 2'd0,
    K_RAMP   = 2'd1,
    K_RAND   = 2'd2,
    K_CHANCE = 2'd3
  } kind_e;

  state_e state_q;
  kind_e  kind_q;
  item_t  item_q;
  res_t   res_q;
  logic   res_valid_q;

  logic        playing_q, muted_q, fired_q;
  logic [15:0] fc_q, interval_q, lfsr_q;
  logic [4:0]  pos_q;
  logic [7:0]  bar_q;
  logic [9:0]  tnow_q, ttgt_q;
  logic [2:0]  mode_q;
  logic [10:0] comp_q;
  logic [31:0] elapsed_q;
  logic [1:0]  snd_q;
  logic [31:0] prod_q;

  logic               div_start_q;
  logic [DivNumW-1:0] div_num_q;
  logic [DivDenW-1:0] div_den_q;
  logic               div_busy, div_done;
  logic [DivNumW-1:0] div_quo;
  logic [DivDenW-1:0] div_rem;

  logic [5:0]  bpb_eff;
  logic [4:0]  pos_inc, pos_n;
  logic [15:0] lfsr_n;
  logic [15:0] rand_mod;
  logic [10:0] t_sum;
  logic [7:0]  bar_inc;
  logic [11:0] cnt_lim;
  logic signed [10:0] delta;
  logic signed [22:0] ramp_prod, ramp_adj;
  logic [9:0]  ramp_tgt;
  logic [12:0] f1;
  logic [9:0]  b1;
  logic [1:0]  pat_snd;
  logic        emit_ok;

  mbs_div #(
    .NumW(DivNumW),
    .DenW(DivDenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_comb begin
    if (cfg_i.beats_per_bar == 5'd0) begin
      bpb_eff = 6'd1;
    end else if ({1'b0, cfg_i.beats_per_bar} > MaxBt) begin
      bpb_eff = MaxBt;
    end else begin
      bpb_eff = {1'b0, cfg_i.beats_per_bar};
    end
    pos_inc = (pos_q == BeatNone) ? 5'd0 : pos_q + 5'd1;
    pos_n   = ({1'b0, pos_inc} >= bpb_eff) ? 5'd0 : pos_inc;
    lfsr_n  = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LfsrTaps : 16'h0000);
    rand_mod = lfsr_q - ({6'd0, prod_q[31:22]} * {9'd0, LfsrMod});
    t_sum   = {1'b0, ttgt_q} + {1'b0, cfg_i.step_value};
    bar_inc = (bar_q == 8'd255) ? bar_q : bar_q + 8'd1;
    cnt_lim = {5'd0, cfg_i.period_bars} + {2'd0, cfg_i.step_value};
    delta     = $signed({1'b0, cfg_i.end_bpm}) - $signed({1'b0, cfg_i.start_bpm});
    ramp_prod = 23'(delta * $signed({1'b0, div_quo[10:0]}));
    ramp_adj  = ramp_prod[22] ? ramp_prod + 23'sd1023 : ramp_prod;
    ramp_tgt  = cfg_i.start_bpm + 10'(ramp_adj >>> 10);
    f1 = (item_q.frames == 13'd0) ? 13'd1 : item_q.frames;
    b1 = (ttgt_q == 10'd0) ? 10'd1 : ttgt_q;
    pat_snd = cfg_i.beat_pattern[{pos_q[3:0], 1'b0} +: 2];
  end

  assign item_pop_o  = (state_q == S_IDLE) && item_valid_i;
  assign emit_ok     = !res_valid_q || res_pop_i;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && emit_ok) begin
      res_q.click_sound <= snd_q;
      res_q.beat_fired  <= fired_q;
      res_q.beat_index  <= (pos_q == BeatNone) ? 4'd0 : pos_q[3:0];
      res_q.current_bpm <= tnow_q;
      res_q.active_mode <= mode_q;
      res_q.progress    <= comp_q;
    end
    if (item_pop_o) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_COMP;
      res_valid_q <= 1'b0;
      playing_q   <= 1'b0;
      muted_q     <= 1'b0;
      fired_q     <= 1'b0;
      snd_q       <= 2'd0;
      fc_q        <= 16'd0;
      interval_q  <= 16'd1;
      lfsr_q      <= LfsrSeed;
      pos_q       <= BeatNone;
      bar_q       <= 8'd0;
      tnow_q      <= 10'd0;
      ttgt_q      <= 10'd120;
      mode_q      <= ModeNone;
      comp_q      <= 11'd0;
      elapsed_q   <= 32'd0;
      prod_q      <= 32'd0;
      div_start_q <= 1'b0;
      div_num_q   <= '0;
      div_den_q   <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (state_q == S_EMIT && emit_ok) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            snd_q   <= 2'd0;
            fired_q <= 1'b0;
            state_q <= S_EMIT;
            case (item_i.op)
              OP_TICK: begin
                if (elapsed_q != 32'hFFFF_FFFF) begin
                  elapsed_q <= elapsed_q + 32'd1;
                end
                if (playing_q) begin
                  div_start_q <= 1'b1;
                  div_num_q   <= DivNumW'(fc_q);
                  div_den_q   <= DivDenW'(interval_q);
                  state_q     <= S_FCDIV;
                end
              end
              OP_PLAY: playing_q <= 1'b1;
              OP_STOP: begin
                playing_q <= 1'b0;
                fc_q      <= 16'd0;
                muted_q   <= 1'b0;
                mode_q    <= ModeNone;
                pos_q     <= BeatNone;
                bar_q     <= 8'd0;
                comp_q    <= 11'd0;
              end
              OP_TRAIN: begin
                if (cfg_i.training_mode <= ModeRandBt) begin
                  mode_q <= cfg_i.training_mode;
                  if (cfg_i.training_mode == ModeRampBar) begin
                    ttgt_q <= cfg_i.start_bpm;
                  end else if (cfg_i.training_mode == ModeRampTck) begin
                    ttgt_q    <= cfg_i.start_bpm;
                    elapsed_q <= 32'd0;
                  end else if (cfg_i.training_mode == ModeRandBar ||
                               cfg_i.training_mode == ModeRandBt) begin
                    if (cfg_i.step_value >= {3'd0, PctFull}) begin
                      comp_q <= ProgDone;
                    end else begin
                      prod_q  <= {17'd0, cfg_i.step_value[6:0], 8'd0} * {16'd0, PctRecip};
                      kind_q  <= K_CHANCE;
                      state_q <= S_MDIV;
                    end
                  end
                end
              end
              OP_TEMPO: ttgt_q <= item_i.tempo;
              default: ;
            endcase
          end
        end

        S_FCDIV: begin
          if (div_done) begin
            if (div_rem != '0) begin
              if (fc_q != 16'hFFFF) begin
                fc_q <= fc_q + 16'd1;
              end
              state_q <= S_EMIT;
            end else begin
              fired_q <= 1'b1;
              fc_q    <= 16'd1;
              pos_q   <= pos_n;
              state_q <= S_SOUND;
              case (mode_q)
                ModeRampBar: begin
                  if (pos_n == 5'd0) begin
                    if (bar_q >= {1'b0, cfg_i.period_bars}) begin
                      bar_q <= 8'd1;
                      if (t_sum >= {1'b0, cfg_i.end_bpm}) begin
                        ttgt_q <= cfg_i.end_bpm;
                        comp_q <= ProgDone;
                        mode_q <= ModeNone;
                      end else begin
                        ttgt_q <= t_sum[9:0];
                        if (cfg_i.end_bpm > cfg_i.start_bpm &&
                            t_sum >= {1'b0, cfg_i.start_bpm}) begin
                          div_start_q <= 1'b1;
                          div_num_q   <= DivNumW'({t_sum - {1'b0, cfg_i.start_bpm}, 10'd0});
                          div_den_q   <= DivDenW'(cfg_i.end_bpm - cfg_i.start_bpm);
                          kind_q      <= K_COMP;
                          state_q     <= S_MDIV;
                        end else begin
                          comp_q <= 11'd0;
                        end
                      end
                    end else begin
                      bar_q <= bar_inc;
                    end
                  end
                end
                ModeRampTck: begin
                  if (elapsed_q > cfg_i.ramp_ticks || cfg_i.ramp_ticks == 32'd0) begin
                    ttgt_q <= cfg_i.end_bpm;
                    comp_q <= ProgDone;
                    mode_q <= ModeNone;
                  end else begin
                    div_start_q <= 1'b1;
                    div_num_q   <= {elapsed_q, 10'd0};
                    div_den_q   <= cfg_i.ramp_ticks;
                    kind_q      <= K_RAMP;
                    state_q     <= S_MDIV;
                  end
                end
                ModeRandBar, ModeRandBt: begin
                  if (pos_n == 5'd0 || mode_q == ModeRandBt) begin
                    lfsr_q  <= lfsr_n;
                    prod_q  <= {16'd0, lfsr_n} * {16'd0, RandRecip};
                    kind_q  <= K_RAND;
                    state_q <= S_MDIV;
                  end
                end
                ModeCntBar: begin
                  if (pos_n == 5'd0) begin
                    bar_q <= bar_inc;
                    if (bar_q >= {1'b0, cfg_i.period_bars}) begin
                      muted_q <= 1'b1;
                      if ({4'd0, bar_q} >= cnt_lim) begin
                        bar_q   <= 8'd1;
                        muted_q <= 1'b0;
                      end
                    end
                  end
                end
                default: muted_q <= 1'b0;
              endcase
            end
          end
        end

        S_MDIV: begin
          if (kind_q == K_RAND) begin
            muted_q <= (rand_mod <= {6'd0, cfg_i.step_value});
            state_q <= S_SOUND;
          end else if (kind_q == K_CHANCE) begin
            comp_q  <= {1'b0, prod_q[29:20]};
            state_q <= S_EMIT;
          end else if (div_done) begin
            state_q <= S_SOUND;
            case (kind_q)
              K_COMP: comp_q <= div_quo[10:0];
              K_RAMP: begin
                comp_q <= div_quo[10:0];
                ttgt_q <= ramp_tgt;
              end
              default: ;
            endcase
          end
        end

        S_SOUND: begin
          snd_q   <= (!muted_q && pos_q < 5'd16) ? pat_snd : 2'd0;
          state_q <= S_EMIT;
          if (tnow_q != ttgt_q) begin
            tnow_q      <= ttgt_q;
            div_start_q <= 1'b1;
            div_num_q   <= ClickNum;
            div_den_q   <= DivDenW'(f1 * b1);
            state_q     <= S_IDIV;
          end
        end

        S_IDIV: begin
          if (div_done) begin
            if (div_quo == '0) begin
              interval_q <= 16'd1;
            end else if (div_quo > DivNumW'(16'hFFFF)) begin
              interval_q <= 16'hFFFF;
            end else begin
              interval_q <= div_quo[15:0];
            end
            state_q <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (emit_ok) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.progress <= ProgDone)
    else $error("progress above done");

  a_interval_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    interval_q != 16'd0)
    else $error("click interval zero");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> !div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire
